[rtl/ca3d_pkg.sv]
// Shared types, constants and helpers for the 3D life automaton step engine.
// No dependencies; imported by cellular_automaton_3d_step.
package ca3d_pkg;

    // Grid bounds
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 16;
    localparam int MAX_SLICES  = 16;

    // Rule and neighbourhood
    localparam int BIRTH_COUNT = 4;
    localparam int NEIGHBOURS  = 26;
    localparam int DIM_MIN     = 3;

    // Field and register widths
    localparam int CMD_W   = 2;
    localparam int FIDX_W  = 4;
    localparam int CFG_W   = 5;
    localparam int CFGI_W  = 2;
    localparam int CNT_W   = $clog2(NEIGHBOURS + 1);

    // Internal index widths
    localparam int ROW_IW  = $clog2(MAX_ROWS);
    localparam int COL_IW  = $clog2(MAX_COLUMNS);
    localparam int SLC_IW  = $clog2(MAX_SLICES);
    localparam int WORDS   = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W  = $clog2(WORDS);

    typedef logic [MAX_SLICES-1:0] t_word;
    typedef logic [ADDR_W-1:0]     t_addr;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [CFGI_W-1:0] {
        CFG_ROWS    = 2'd0,
        CFG_COLUMNS = 2'd1,
        CFG_SLICES  = 2'd2,
        CFG_RUNNING = 2'd3
    } t_cfg_idx;

    // Saturate a dimension register to DIM_MIN .. maxv
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int maxv);
        logic [CFG_W-1:0] res;
        res = v;
        if (int'(v) < DIM_MIN) begin
            res = CFG_W'(DIM_MIN);
        end else if (int'(v) > maxv) begin
            res = CFG_W'(maxv);
        end
        return res;
    endfunction

endpackage

[rtl/cellular_automaton_3d_step.sv]
// Top level of the 3D life automaton: grid memory, step sequencer, command channel.
// Depends on ca3d_pkg for widths, command codes and the dimension clamp.
//
//  channel  direction  handshake               payload
//  -------  ---------  ----------------------  ------------------------------------
//  in       sink       i_in_valid / o_in_stall  i_command i_row i_column i_slice i_value
//  out      source     o_out_valid / i_out_stall o_cell_value o_accepted
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// One word at a time: a read passes ST_READ and a write ST_RMW on its way to ST_RESULT;
// clear and rejected words go straight there. A step makes nine neighbour-word reads per
// grid column word through the single read port of the grid memory into a slice-wide
// counter bank, passes ST_FINISH and ST_STORE, and then copies the new generation back.
// Reset clears the per-word valid bits at once, so no clearing pass is needed.
// A finished word waits in the output register while a new word is accepted;
// o_in_stall is high while a command is being worked on.
module cellular_automaton_3d_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ca3d_pkg::CMD_W-1:0]   i_command,
    input  logic [ca3d_pkg::FIDX_W-1:0]  i_row,
    input  logic [ca3d_pkg::FIDX_W-1:0]  i_column,
    input  logic [ca3d_pkg::FIDX_W-1:0]  i_slice,
    input  logic                         i_value,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_cell_value,
    output logic                         o_accepted,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ca3d_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [ca3d_pkg::CFG_W-1:0]   i_cfg_data
);
    import ca3d_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RMW,
        ST_GATHER,
        ST_FINISH,
        ST_STORE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_RESULT
    } t_state;

    // Control registers
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_nr, r_nc, r_ns;
    logic                r_running;
    logic [WORDS-1:0]    r_vld;
    logic                r_rd_vld;
    logic                r_out_valid, n_out_valid;
    logic                r_out_cell, n_out_cell;
    logic                r_out_acc, n_out_acc;
    logic                r_pend, n_pend;

    // Datapath registers
    t_addr               r_addr, n_addr;
    logic [SLC_IW-1:0]   r_s, n_s;
    logic                r_v, n_v;
    logic                r_res_cell, n_res_cell;
    logic                r_res_acc, n_res_acc;
    logic [ROW_IW-1:0]   r_ci, n_ci;
    logic [COL_IW-1:0]   r_cj, n_cj;
    logic [1:0]          r_dr, n_dr;
    logic [1:0]          r_dc, n_dc;
    logic                r_pend_first, n_pend_first;
    logic                r_pend_center, n_pend_center;
    logic [CNT_W-1:0]    r_acc [MAX_SLICES];
    logic [CNT_W-1:0]    n_acc [MAX_SLICES];
    t_word               r_old, n_old;
    t_word               r_rd_word;
    t_word               r_nx_word;

    // Memories
    t_word               cell_mem [WORDS];
    t_word               nx_mem [WORDS];

    // Combinational helpers
    logic                in_acc;
    logic                in_box;
    t_addr               in_addr;
    t_addr               cur_addr;
    t_addr               nb_addr;
    t_addr               rd_addr;
    logic                wr_en;
    t_addr               wr_addr;
    t_word               wr_word;
    logic                nx_wr_en;
    logic                clr_all;
    t_word               rd_eff;
    t_word               new_word;
    logic [ROW_IW-1:0]   nr_last, row_lo, row_hi, nb_row;
    logic [COL_IW-1:0]   nc_last, col_lo, col_hi, nb_col;
    logic [SLC_IW-1:0]   ns_last;
    logic                last_word;

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_cell;
    assign o_accepted   = r_out_acc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign in_box  = (int'(i_row) < int'(r_nr)) && (int'(i_column) < int'(r_nc))
                  && (int'(i_slice) < int'(r_ns));
    assign in_addr  = ADDR_W'(int'(i_row) * MAX_COLUMNS + int'(i_column));
    assign cur_addr = ADDR_W'(int'(r_ci) * MAX_COLUMNS + int'(r_cj));
    assign rd_eff   = r_rd_vld ? r_rd_word : '0;

    // Toroidal neighbour word address
    assign nr_last = ROW_IW'(r_nr - CFG_W'(1));
    assign nc_last = COL_IW'(r_nc - CFG_W'(1));
    assign ns_last = SLC_IW'(r_ns - CFG_W'(1));
    assign row_lo  = (r_ci == '0) ? nr_last : r_ci - ROW_IW'(1);
    assign row_hi  = (r_ci == nr_last) ? '0 : r_ci + ROW_IW'(1);
    assign col_lo  = (r_cj == '0) ? nc_last : r_cj - COL_IW'(1);
    assign col_hi  = (r_cj == nc_last) ? '0 : r_cj + COL_IW'(1);
    assign last_word = (r_ci == nr_last) && (r_cj == nc_last);

    always_comb begin
        case (r_dr)
            2'd0:    nb_row = row_lo;
            2'd1:    nb_row = r_ci;
            default: nb_row = row_hi;
        endcase
        case (r_dc)
            2'd0:    nb_col = col_lo;
            2'd1:    nb_col = r_cj;
            default: nb_col = col_hi;
        endcase
    end
    assign nb_addr = ADDR_W'(int'(nb_row) * MAX_COLUMNS + int'(nb_col));

    // Counter bank: add each lane's slice neighbours from the word just read
    always_comb begin
        int          idx_l;
        int          idx_r;
        logic        bit_l;
        logic        bit_r;
        logic        bit_c;
        logic [CNT_W-1:0] contrib;
        for (int k = 0; k < MAX_SLICES; k++) begin
            idx_l   = (k == 0) ? MAX_SLICES - 1 : k - 1;
            idx_r   = (k == MAX_SLICES - 1) ? 0 : k + 1;
            bit_l   = (k == 0) ? rd_eff[ns_last] : rd_eff[idx_l];
            bit_r   = (SLC_IW'(k) == ns_last) ? rd_eff[0] : rd_eff[idx_r];
            bit_c   = rd_eff[k] && !r_pend_center;
            contrib = CNT_W'(bit_l) + CNT_W'(bit_r) + CNT_W'(bit_c);
            if (r_pend) begin
                n_acc[k] = r_pend_first ? contrib : r_acc[k] + contrib;
            end else begin
                n_acc[k] = r_acc[k];
            end
            new_word[k] = (k < int'(r_ns)) ? (r_acc[k] == CNT_W'(BIRTH_COUNT))
                                           : r_old[k];
        end
        n_old = (r_pend && r_pend_center) ? rd_eff : r_old;
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_s           = r_s;
        n_v           = r_v;
        n_res_cell    = r_res_cell;
        n_res_acc     = r_res_acc;
        n_ci          = r_ci;
        n_cj          = r_cj;
        n_dr          = r_dr;
        n_dc          = r_dc;
        n_pend        = 1'b0;
        n_pend_first  = r_pend_first;
        n_pend_center = r_pend_center;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_cell    = r_out_cell;
        n_out_acc     = r_out_acc;
        rd_addr       = r_addr;
        wr_en         = 1'b0;
        wr_addr       = r_addr;
        wr_word       = rd_eff;
        nx_wr_en      = 1'b0;
        clr_all       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_addr     = in_addr;
                    n_s        = SLC_IW'(i_slice);
                    n_v        = i_value;
                    n_res_cell = 1'b0;
                    n_res_acc  = 1'b0;
                    n_state    = ST_RESULT;
                    rd_addr    = in_addr;
                    unique case (t_cmd'(i_command))
                        CMD_WRITE: begin
                            if (!r_running && in_box) begin
                                n_res_acc = 1'b1;
                                n_state   = ST_RMW;
                            end
                        end
                        CMD_READ: begin
                            if (in_box) begin
                                n_res_acc = 1'b1;
                                n_state   = ST_READ;
                            end
                        end
                        CMD_STEP: begin
                            if (r_running) begin
                                n_res_acc = 1'b1;
                                n_ci      = '0;
                                n_cj      = '0;
                                n_dr      = '0;
                                n_dc      = '0;
                                n_state   = ST_GATHER;
                            end
                        end
                        CMD_CLEAR: begin
                            if (!r_running) begin
                                n_res_acc = 1'b1;
                                clr_all   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res_cell = rd_eff[r_s];
                n_state    = ST_RESULT;
            end
            ST_RMW: begin
                wr_en        = 1'b1;
                wr_word      = rd_eff;
                wr_word[r_s] = r_v;
                n_state      = ST_RESULT;
            end
            ST_GATHER: begin
                // issue one neighbour word; it is counted next cycle
                rd_addr       = nb_addr;
                n_pend        = 1'b1;
                n_pend_first  = (r_dr == 2'd0) && (r_dc == 2'd0);
                n_pend_center = (r_dr == 2'd1) && (r_dc == 2'd1);
                if (r_dc == 2'd2) begin
                    n_dc = '0;
                    if (r_dr == 2'd2) begin
                        n_dr    = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_dr = r_dr + 2'd1;
                    end
                end else begin
                    n_dc = r_dc + 2'd1;
                end
            end
            ST_FINISH: begin
                n_state = ST_STORE;
            end
            ST_STORE: begin
                nx_wr_en = 1'b1;
                if (last_word) begin
                    n_ci    = '0;
                    n_cj    = '0;
                    n_state = ST_COPY_RD;
                end else begin
                    n_state = ST_GATHER;
                    if (r_cj == nc_last) begin
                        n_cj = '0;
                        n_ci = r_ci + ROW_IW'(1);
                    end else begin
                        n_cj = r_cj + COL_IW'(1);
                    end
                end
            end
            ST_COPY_RD: begin
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_word = r_nx_word;
                if (last_word) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_COPY_RD;
                    if (r_cj == nc_last) begin
                        n_cj = '0;
                        n_ci = r_ci + ROW_IW'(1);
                    end else begin
                        n_cj = r_cj + COL_IW'(1);
                    end
                end
            end
            ST_RESULT: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_res_cell;
                    n_out_acc   = r_res_acc;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    // State, configuration, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nr        <= CFG_W'(MAX_ROWS);
            r_nc        <= CFG_W'(MAX_COLUMNS);
            r_ns        <= CFG_W'(MAX_SLICES);
            r_running   <= 1'b0;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_cell  <= 1'b0;
            r_out_acc   <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_cell  <= n_out_cell;
            r_out_acc   <= n_out_acc;
            r_pend      <= n_pend;
            r_rd_vld    <= r_vld[rd_addr];
            if (clr_all) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ROWS:    r_nr      <= clamp_dim(i_cfg_data, MAX_ROWS);
                    CFG_COLUMNS: r_nc      <= clamp_dim(i_cfg_data, MAX_COLUMNS);
                    CFG_SLICES:  r_ns      <= clamp_dim(i_cfg_data, MAX_SLICES);
                    CFG_RUNNING: r_running <= i_cfg_data[0];
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_addr        <= n_addr;
        r_s           <= n_s;
        r_v           <= n_v;
        r_res_cell    <= n_res_cell;
        r_res_acc     <= n_res_acc;
        r_ci          <= n_ci;
        r_cj          <= n_cj;
        r_dr          <= n_dr;
        r_dc          <= n_dc;
        r_pend_first  <= n_pend_first;
        r_pend_center <= n_pend_center;
        r_acc         <= n_acc;
        r_old         <= n_old;
    end

    // Grid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_word;
        end
        r_rd_word <= cell_mem[rd_addr];
    end

    // Next-generation scratch memory
    always_ff @(posedge i_clk) begin
        if (nx_wr_en) begin
            nx_mem[cur_addr] <= new_word;
        end
        r_nx_word <= nx_mem[cur_addr];
    end

    // Clear empties the whole grid by the cycle after it is accepted
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_CLEAR) && !r_running |=> (r_vld == '0))
        else $error("clear left live words in the grid");

    // A read outside the grid is refused straight away
    a_read_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_READ) && !in_box
        |=> (r_state == ST_RESULT) && !r_res_acc && !r_res_cell)
        else $error("out-of-range read was not refused");

    // Lane 0 never counts more neighbours than exist
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE) |-> (int'(r_acc[0]) <= NEIGHBOURS))
        else $error("neighbour count overflow");

    // A step while stopped leaves the grid alone
    a_step_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_command == CMD_STEP) && !r_running
        |=> (r_state == ST_RESULT) && !r_res_acc)
        else $error("step taken while stopped");

endmodule
